// File: rtl/hklt_pkg.sv
package hklt_pkg;

   localparam int KEY_BITS = 64;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MOD
   } state_type;

   localparam logic [2:0] STATUS_HIT     = 3'd0;
   localparam logic [2:0] STATUS_MISS    = 3'd1;
   localparam logic [2:0] STATUS_UPDATED = 3'd2;
   localparam logic [2:0] STATUS_FILLED  = 3'd3;
   localparam logic [2:0] STATUS_EVICTED = 3'd4;

endpackage

// File: rtl/hash_keyed_lookup_table_core.sv
// Fully associative key/value table of ENTRIES slots, 64-bit keys and values.
// Command channel: req_func/req_key/req_entry_value are taken at a rising edge
// with start high and busy low; busy stays high until the result is out.
// req_func 0 looks the key up, 1 updates the matching slot, else fills the
// lowest empty slot, else evicts slot key mod ENTRIES.
// Result channel: rsp_valid is high for one cycle with rsp_status,
// rsp_found_value and rsp_slot; the receiver takes it in that cycle and
// cannot stall it. The next item may be started in that same cycle.
// Slots fill from index 0 upward and never empty, so only the first
// fill-count slots are searched, one per cycle through the key/value memory
// read port. An insert into a full table then builds key mod ENTRIES one key
// byte at a time, each byte by a reciprocal multiply and then a subtract.
// Reset clears the fill count, which marks every slot empty at once; the key
// and value memories are not cleared and no reset sweep is needed.
module hash_keyed_lookup_table_core #(
   parameter int ENTRIES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_func,
   input  logic [63:0] req_key,
   input  logic [63:0] req_entry_value,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [63:0] rsp_found_value,
   output logic [7:0]  rsp_slot
);
   import hklt_pkg::*;

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int REM_W = IDX_W + 1;
   localparam int DIGITS = KEY_BITS / 8;
   localparam int X_W    = IDX_W + 8;
   localparam int RCP_SH = X_W + IDX_W;
   localparam int PROD_W = X_W + RCP_SH;
   localparam logic [REM_W-1:0] ENT_REM  = REM_W'(ENTRIES);
   localparam logic [CNT_W-1:0] ENT_CNT  = CNT_W'(ENTRIES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
   // ceil(2^RCP_SH / ENTRIES): exact quotient for any dividend below 2^X_W
   localparam logic [RCP_SH-1:0] RCP_M =
      RCP_SH'(((64'd1 << RCP_SH) + 64'(ENTRIES) - 64'd1) / 64'(ENTRIES));

   logic [63:0] key_mem [ENTRIES];
   logic [63:0] value_mem [ENTRIES];

   state_type        state_ff, state_in;
   logic             func_ff;
   logic [63:0]      key_ff, value_ff;
   logic [IDX_W-1:0] addr_ff, addr_in;
   logic             pend_ff, pend_in;
   logic [IDX_W-1:0] pend_idx_ff, pend_idx_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [IDX_W-1:0] rem_ff, rem_in;
   logic [2:0]       dig_ff, dig_in;
   logic             sub_ff, sub_in;
   logic [X_W-1:0]   x_ff, x_in;
   logic [7:0]       q_ff, q_in;
   logic [63:0]      key_rd_ff, val_rd_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       rsp_status_ff, rsp_status_in;
   logic [63:0]      rsp_found_ff, rsp_found_in;
   logic [7:0]       rsp_slot_ff, rsp_slot_in;

   logic             accept;
   logic             key_eq, at_last, empty, full;
   logic [X_W-1:0]   x_cur;
   logic [7:0]       q_cur;
   logic [X_W-1:0]   q_mul;
   logic [IDX_W-1:0] rem_diff;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;

   assign accept  = start && (state_ff == ST_IDLE);
   assign key_eq  = pend_ff && (key_rd_ff == key_ff);
   assign at_last = pend_ff && (CNT_W'(pend_idx_ff) == (fill_ff - CNT_W'(1)));
   assign empty   = (fill_ff == '0);
   assign full    = (fill_ff == ENT_CNT);

   // key mod ENTRIES, one byte per step, most significant byte first
   assign x_cur    = {rem_ff, key_ff[{~dig_ff, 3'b000} +: 8]};
   assign q_cur    = 8'((PROD_W'(x_cur) * PROD_W'(RCP_M)) >> RCP_SH);
   assign q_mul    = X_W'(q_ff) * X_W'(ENT_REM);
   assign rem_diff = IDX_W'(x_ff - q_mul);

   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      pend_in       = pend_ff;
      pend_idx_in   = pend_idx_ff;
      fill_in       = fill_ff;
      rem_in        = rem_ff;
      dig_in        = dig_ff;
      sub_in        = sub_ff;
      x_in          = x_ff;
      q_in          = q_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_slot_in   = rsp_slot_ff;
      wr_en         = 1'b0;
      wr_addr       = pend_idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_SCAN;
               addr_in  = '0;
               pend_in  = 1'b0;
            end
         end
         ST_SCAN: begin
            pend_in     = 1'b1;
            pend_idx_in = addr_ff;
            addr_in     = (addr_ff == LAST_IDX) ? addr_ff : addr_ff + IDX_W'(1);
            if (!empty && key_eq) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_slot_in  = 8'(pend_idx_ff);
               if (func_ff) begin
                  wr_en         = 1'b1;
                  wr_addr       = pend_idx_ff;
                  rsp_status_in = STATUS_UPDATED;
                  rsp_found_in  = '0;
               end else begin
                  rsp_status_in = STATUS_HIT;
                  rsp_found_in  = val_rd_ff;
               end
            end else if (empty || at_last) begin
               if (!func_ff) begin
                  state_in      = ST_IDLE;
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_MISS;
                  rsp_found_in  = '0;
                  rsp_slot_in   = '0;
               end else if (!full) begin
                  // fill count is below ENTRIES here, so it fits an index
                  state_in      = ST_IDLE;
                  wr_en         = 1'b1;
                  wr_addr       = fill_ff[IDX_W-1:0];
                  fill_in       = fill_ff + CNT_W'(1);
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_FILLED;
                  rsp_found_in  = '0;
                  rsp_slot_in   = 8'(fill_ff);
               end else begin
                  state_in = ST_MOD;
                  rem_in   = '0;
                  dig_in   = '0;
                  sub_in   = 1'b0;
               end
            end
         end
         ST_MOD: begin
            if (!sub_ff) begin
               // quotient digit by reciprocal multiply
               x_in   = x_cur;
               q_in   = q_cur;
               sub_in = 1'b1;
            end else begin
               rem_in = rem_diff;
               sub_in = 1'b0;
               dig_in = dig_ff + 3'd1;
               if (dig_ff == 3'(DIGITS - 1)) begin
                  state_in      = ST_IDLE;
                  wr_en         = 1'b1;
                  wr_addr       = rem_diff;
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_EVICTED;
                  rsp_found_in  = '0;
                  rsp_slot_in   = 8'(rem_diff);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff  <= req_func;
         key_ff   <= req_key;
         value_ff <= req_entry_value;
      end
      addr_ff       <= addr_in;
      pend_idx_ff   <= pend_idx_in;
      rem_ff        <= rem_in;
      dig_ff        <= dig_in;
      sub_ff        <= sub_in;
      x_ff          <= x_in;
      q_ff          <= q_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   // key and value memories: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr]   <= key_ff;
         value_mem[wr_addr] <= value_ff;
      end
      key_rd_ff <= key_mem[addr_ff];
      val_rd_ff <= value_mem[addr_ff];
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_value = rsp_found_ff;
   assign rsp_slot        = rsp_slot_ff;

endmodule

// File: rtl/hklt_checker.sv
module hklt_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [2:0]  rsp_status,
   input logic [63:0] rsp_found_value,
   input logic [7:0]  rsp_slot
);
   import hklt_pkg::*;

   // an accepted item always makes the core go busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("item accepted without going busy");

   // a result only closes out an item that was in progress
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without an item in progress");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_HIT || rsp_status == STATUS_MISS ||
                     rsp_status == STATUS_UPDATED || rsp_status == STATUS_FILLED ||
                     rsp_status == STATUS_EVICTED))
      else $error("result status out of range");

   a_value_only_on_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_HIT |-> rsp_found_value == '0)
      else $error("found value nonzero without a lookup hit");

   a_miss_slot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_MISS |-> rsp_slot == '0)
      else $error("slot nonzero on a lookup miss");

endmodule

bind hash_keyed_lookup_table_core hklt_checker u_hklt_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_status      (rsp_status),
   .rsp_found_value (rsp_found_value),
   .rsp_slot        (rsp_slot)
);

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;
   import hklt_pkg::*;

   localparam int TABLE_SIZE = 256;
   localparam int RANDOM_ITEMS = 750;
   localparam int IDLE_LIMIT = 4000;
   localparam int DRAIN_CYCLES = TABLE_SIZE + 80;

   localparam logic OP_LOOKUP = 1'b0;
   localparam logic OP_INSERT = 1'b1;

   typedef struct {
      logic        func;
      logic [63:0] key;
      logic [63:0] value;
   } table_op_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [63:0] found_value;
      logic [7:0]  slot;
   } table_rsp_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_func = OP_LOOKUP;
   logic [63:0] req_key = '0;
   logic [63:0] req_entry_value = '0;
   logic        rsp_valid;
   logic [2:0]  rsp_status;
   logic [63:0] rsp_found_value;
   logic [7:0]  rsp_slot;

   // shadow copy of the table
   logic [63:0] slot_keys [TABLE_SIZE];
   logic [63:0] slot_values [TABLE_SIZE];
   bit          slot_valid [TABLE_SIZE] = '{default: 1'b0};

   table_op_type  queued_ops [$];
   table_rsp_type awaited_replies [$];
   logic [63:0]   key_pool [$];

   table_op_type  op_on_bus;
   table_rsp_type want;
   int          burst_left;
   int          gap_left;
   int          ops_accepted = 0;
   int          idle_cycles = 0;
   int          error_count = 0;
   int          status_seen [8] = '{default: 0};

   hash_keyed_lookup_table_core #(
      .ENTRIES(TABLE_SIZE)
   ) uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_func(req_func),
      .req_key(req_key),
      .req_entry_value(req_entry_value),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_found_value(rsp_found_value),
      .rsp_slot(rsp_slot)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic table_rsp_type apply_table_op(table_op_type op);
      table_rsp_type r;
      int hit_idx;
      int free_idx;
      int idx;
      r.status = STATUS_MISS;
      r.found_value = '0;
      r.slot = '0;
      hit_idx = -1;
      free_idx = -1;
      for (int i = 0; i < TABLE_SIZE; i++) begin
         if (hit_idx < 0 && slot_valid[i] && slot_keys[i] == op.key)
            hit_idx = i;
         if (free_idx < 0 && !slot_valid[i])
            free_idx = i;
      end
      if (op.func == OP_LOOKUP) begin
         if (hit_idx >= 0) begin
            r.status = STATUS_HIT;
            r.found_value = slot_values[hit_idx];
            r.slot = 8'(hit_idx);
         end
      end else begin
         if (hit_idx >= 0) begin
            idx = hit_idx;
            r.status = STATUS_UPDATED;
         end else begin
            if (free_idx >= 0) begin
               idx = free_idx;
               r.status = STATUS_FILLED;
            end else begin
               idx = int'(op.key % 64'(TABLE_SIZE));
               r.status = STATUS_EVICTED;
            end
            slot_keys[idx] = op.key;
            slot_valid[idx] = 1'b1;
         end
         slot_values[idx] = op.value;
         r.slot = 8'(idx);
      end
      return r;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // new key for an insert; some land on the first or last victim slot
   function automatic logic [63:0] fresh_key();
      logic [63:0] k;
      k = rand64();
      case ($urandom_range(0, 19))
         0: k[7:0] = 8'h00;
         1: k[7:0] = 8'hFF;
         default: ;
      endcase
      key_pool.push_back(k);
      return k;
   endfunction

   function automatic logic [63:0] pool_key();
      return key_pool[$urandom_range(0, key_pool.size() - 1)];
   endfunction

   task automatic queue_op(input logic f, input logic [63:0] k, input logic [63:0] v);
      table_op_type op;
      op.func = f;
      op.key = k;
      op.value = v;
      queued_ops.push_back(op);
   endtask

   // driver: bursts of items separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         req_func <= OP_LOOKUP;
         req_key <= '0;
         req_entry_value <= '0;
         burst_left = $urandom_range(1, 30);
         gap_left = 0;
      end else if (!start || !busy) begin
         if (start) begin
            awaited_replies.push_back(apply_table_op(op_on_bus));
            ops_accepted++;
         end
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (queued_ops.size() > 0) begin
            op_on_bus = queued_ops.pop_front();
            start <= 1'b1;
            req_func <= op_on_bus.func;
            req_key <= op_on_bus.key;
            req_entry_value <= op_on_bus.value;
            burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 30);
               case ($urandom_range(0, 5))
                  0, 1: gap_left = 0;
                  2: gap_left = $urandom_range(100, 400);
                  default: gap_left = $urandom_range(1, 40);
               endcase
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: results cannot be held off, check each strobe
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if ((start && !busy) || rsp_valid)
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (rsp_valid) begin
            status_seen[rsp_status]++;
            if (awaited_replies.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("unexpected result: status %0d value %h slot %0d",
                           rsp_status, rsp_found_value, rsp_slot);
            end else begin
               want = awaited_replies.pop_front();
               if (rsp_status !== want.status || rsp_found_value !== want.found_value ||
                   rsp_slot !== want.slot) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("mismatch: status %0d/%0d value %h/%h slot %0d/%0d (exp/act)",
                              want.status, rsp_status, want.found_value, rsp_found_value,
                              want.slot, rsp_slot);
               end
            end
         end
      end
   end

   initial begin
      int roll;
      int new_keys;
      int item_target;

      // directed: empty table, extreme keys and values, update, near misses
      queue_op(OP_LOOKUP, 64'h0, 64'h0);
      queue_op(OP_LOOKUP, '1, '1);
      queue_op(OP_INSERT, 64'h0, '1);
      queue_op(OP_INSERT, '1, 64'h0);
      queue_op(OP_LOOKUP, 64'h0, 64'h0);
      queue_op(OP_LOOKUP, '1, 64'h0);
      queue_op(OP_INSERT, 64'h0, 64'h5555_5555_5555_5555);
      queue_op(OP_LOOKUP, 64'h0, '1);
      queue_op(OP_INSERT, 64'h8000_0000_0000_0000, 64'hAAAA_AAAA_AAAA_AAAA);
      queue_op(OP_LOOKUP, 64'h8000_0000_0000_0001, 64'h0);
      queue_op(OP_LOOKUP, 64'h1, 64'h0);
      queue_op(OP_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 64'h0123_4567_89AB_CDEF);
      queue_op(OP_LOOKUP, 64'h8000_0000_0000_0000, 64'h0);
      queue_op(OP_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, '1);
      queue_op(OP_INSERT, '1, '1);
      queue_op(OP_LOOKUP, '1, 64'h0);
      key_pool.push_back(64'h0);
      key_pool.push_back('1);
      key_pool.push_back(64'h8000_0000_0000_0000);
      key_pool.push_back(64'hAAAA_AAAA_AAAA_AAAA);
      new_keys = key_pool.size();
      item_target = queued_ops.size() + RANDOM_ITEMS;

      // fill the table past capacity, mostly inserts of new keys
      while (new_keys < TABLE_SIZE + 24) begin
         roll = $urandom_range(0, 99);
         if (roll < 70) begin
            queue_op(OP_INSERT, fresh_key(), rand64());
            new_keys++;
         end else if (roll < 80)
            queue_op(OP_INSERT, pool_key(), rand64());
         else if (roll < 93)
            queue_op(OP_LOOKUP, pool_key(), rand64());
         else
            queue_op(OP_LOOKUP, pool_key() ^ (64'd1 << $urandom_range(0, 63)), rand64());
      end

      // full table: evictions, updates, hits and misses
      while (queued_ops.size() < item_target) begin
         roll = $urandom_range(0, 99);
         if (roll < 35)
            queue_op(OP_INSERT, fresh_key(), rand64());
         else if (roll < 50)
            queue_op(OP_INSERT, pool_key(), rand64());
         else if (roll < 85)
            queue_op(OP_LOOKUP, pool_key(), rand64());
         else if (roll < 93)
            queue_op(OP_LOOKUP, pool_key() ^ (64'd1 << $urandom_range(0, 63)), rand64());
         else
            queue_op(OP_LOOKUP, rand64(), rand64());
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while ((queued_ops.size() > 0 || start || awaited_replies.size() > 0) &&
             idle_cycles < IDLE_LIMIT)
         @(negedge clock);

      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no progress for %0d cycles", IDLE_LIMIT);
         $display("simulation failed");
      end else begin
         // catch any stray result after the last one
         repeat (DRAIN_CYCLES) @(negedge clock);
         $display("%0d items into a %0d-slot table, %0d errors", ops_accepted, TABLE_SIZE,
                  error_count);
         $display("hits %0d, misses %0d, updates %0d, fills %0d, evictions %0d",
                  status_seen[STATUS_HIT], status_seen[STATUS_MISS],
                  status_seen[STATUS_UPDATED], status_seen[STATUS_FILLED],
                  status_seen[STATUS_EVICTED]);
         if (error_count == 0)
            $display("simulation ok");
         else
            $display("simulation failed");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/hklt_pkg.sv
rtl/hash_keyed_lookup_table_core.sv
rtl/hklt_checker.sv
verif/tb.sv
